// ===== hw/rtl/tlsi_pkg.sv =====
// Package for the two-axis linear step interpolator: position width, action codes
// and the packed beat types of the request and result channels.
// No dependencies.
`default_nettype none

package tlsi_pkg;

    // Width of a motor position in steps, two's complement.
    localparam int POS_BITS = 16;

    // Width of the per-axis error term: it spans (-n, |delta|] with n up to 2^POS_BITS - 1.
    localparam int ERR_BITS = POS_BITS + 2;

    typedef enum logic [1:0] {
        ACT_MOVE = 2'd0,
        ACT_TICK = 2'd1,
        ACT_SET  = 2'd2
    } t_action;

    typedef struct packed {
        t_action                    action;
        logic signed [POS_BITS-1:0] axis1_value;
        logic signed [POS_BITS-1:0] axis2_value;
    } t_in_beat;

    typedef struct packed {
        logic                       step1;
        logic                       step2;
        logic                       dir1;
        logic                       dir2;
        logic signed [POS_BITS-1:0] position1;
        logic signed [POS_BITS-1:0] position2;
        logic                       busy_res;
        logic                       accepted;
    } t_out_beat;

endpackage

`default_nettype wire

// ===== hw/rtl/two_axis_linear_step_interpolator_core.sv =====
// Top level of the two-axis linear step interpolator: move state, per-axis error
// accumulators and the registered result beat. Depends on tlsi_pkg.
`default_nettype none

// Channel     Direction  Handshake                 Beat type
// request     in         i_in_valid / o_in_stall   t_in_beat
// result      out        o_out_valid / i_out_stall t_out_beat
//
// Each request beat is carried out in the cycle it is accepted and its result beat
// appears on the next cycle, so one beat per cycle flows when the result side does
// not stall. The single result register sets that figure: a new request is taken
// whenever that register is empty or is being emptied in the same cycle.
// Synchronous active-low reset clears the positions, the move state and the result
// register; both directions come out of reset as forward.

module two_axis_linear_step_interpolator_core
    import tlsi_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_beat  i_in_beat,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_beat      o_out_beat
);

    // Committed positions, delta magnitudes and the move length n.
    logic signed [POS_BITS-1:0] r_pos1, n_pos1;
    logic signed [POS_BITS-1:0] r_pos2, n_pos2;
    logic [POS_BITS-1:0]        r_mag1, n_mag1;
    logic [POS_BITS-1:0]        r_mag2, n_mag2;
    logic [POS_BITS-1:0]        r_total, n_total;
    logic [POS_BITS-1:0]        r_iter, n_iter;

    // The exact test count*n < i*|delta| is carried incrementally: the error term
    // holds i*|delta| - count*n. On a tick it grows by |delta|; the motor steps when
    // it is positive, and a step takes n back off. No multiplier is needed.
    logic signed [ERR_BITS-1:0] r_err1, n_err1;
    logic signed [ERR_BITS-1:0] r_err2, n_err2;

    logic                       r_dir1, n_dir1;
    logic                       r_dir2, n_dir2;
    logic                       r_moving, n_moving;

    logic                       r_out_valid;
    t_out_beat                  r_out_beat, n_out_beat;

    logic                       w_accept;
    logic signed [POS_BITS:0]   w_delta1, w_delta2;
    logic signed [POS_BITS:0]   w_neg1, w_neg2;
    logic [POS_BITS-1:0]        w_abs1, w_abs2;
    logic signed [ERR_BITS-1:0] w_sum1, w_sum2;
    logic signed [ERR_BITS-1:0] w_total_ext;
    logic                       w_step1, w_step2;

    // The result register empties whenever downstream takes it, so a new request
    // is refused only while a result is held and stalled.
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_accept    = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // Signed deltas with one extra bit so that they are exact.
    assign w_delta1 = {i_in_beat.axis1_value[POS_BITS-1], i_in_beat.axis1_value}
                    - {r_pos1[POS_BITS-1], r_pos1};
    assign w_delta2 = {i_in_beat.axis2_value[POS_BITS-1], i_in_beat.axis2_value}
                    - {r_pos2[POS_BITS-1], r_pos2};
    assign w_neg1   = -w_delta1;
    assign w_neg2   = -w_delta2;
    assign w_abs1   = w_delta1[POS_BITS] ? w_neg1[POS_BITS-1:0] : w_delta1[POS_BITS-1:0];
    assign w_abs2   = w_delta2[POS_BITS] ? w_neg2[POS_BITS-1:0] : w_delta2[POS_BITS-1:0];

    // Error terms for iteration i+1 and the step decisions of a tick.
    assign w_sum1      = r_err1 + $signed({2'b00, r_mag1});
    assign w_sum2      = r_err2 + $signed({2'b00, r_mag2});
    assign w_total_ext = $signed({2'b00, r_total});
    assign w_step1     = r_moving && (w_sum1 > $signed({ERR_BITS{1'b0}}));
    assign w_step2     = r_moving && (w_sum2 > $signed({ERR_BITS{1'b0}}));

    always_comb begin
        n_pos1   = r_pos1;
        n_pos2   = r_pos2;
        n_mag1   = r_mag1;
        n_mag2   = r_mag2;
        n_total  = r_total;
        n_iter   = r_iter;
        n_err1   = r_err1;
        n_err2   = r_err2;
        n_dir1   = r_dir1;
        n_dir2   = r_dir2;
        n_moving = r_moving;

        n_out_beat          = '0;
        n_out_beat.accepted = 1'b0;

        case (i_in_beat.action)
            ACT_MOVE: begin
                if (!r_moving) begin
                    n_pos1   = i_in_beat.axis1_value;
                    n_pos2   = i_in_beat.axis2_value;
                    n_mag1   = w_abs1;
                    n_mag2   = w_abs2;
                    n_total  = (w_abs1 > w_abs2) ? w_abs1 : w_abs2;
                    n_iter   = '0;
                    n_err1   = '0;
                    n_err2   = '0;
                    n_dir1   = ~w_delta1[POS_BITS];
                    n_dir2   = ~w_delta2[POS_BITS];
                    n_moving = (w_abs1 != '0) || (w_abs2 != '0);
                    n_out_beat.accepted = 1'b1;
                end
            end
            ACT_TICK: begin
                n_out_beat.accepted = 1'b1;
                if (r_moving) begin
                    n_err1   = w_step1 ? (w_sum1 - w_total_ext) : w_sum1;
                    n_err2   = w_step2 ? (w_sum2 - w_total_ext) : w_sum2;
                    n_iter   = r_iter + 1'b1;
                    // The last iteration is reached when i+1 equals n.
                    n_moving = (n_iter != r_total);
                end
            end
            ACT_SET: begin
                if (!r_moving) begin
                    n_pos1 = i_in_beat.axis1_value;
                    n_pos2 = i_in_beat.axis2_value;
                    n_out_beat.accepted = 1'b1;
                end
            end
            default: begin
                // The unused action code changes nothing and is reported as refused.
                n_out_beat.accepted = 1'b0;
            end
        endcase

        n_out_beat.step1     = (i_in_beat.action == ACT_TICK) && w_step1;
        n_out_beat.step2     = (i_in_beat.action == ACT_TICK) && w_step2;
        n_out_beat.dir1      = n_dir1;
        n_out_beat.dir2      = n_dir2;
        n_out_beat.position1 = n_pos1;
        n_out_beat.position2 = n_pos2;
        n_out_beat.busy_res  = n_moving;
    end

    // Move state advances only on an accepted request beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos1   <= '0;
            r_pos2   <= '0;
            r_mag1   <= '0;
            r_mag2   <= '0;
            r_total  <= '0;
            r_iter   <= '0;
            r_err1   <= '0;
            r_err2   <= '0;
            r_dir1   <= 1'b1;
            r_dir2   <= 1'b1;
            r_moving <= 1'b0;
        end else if (w_accept) begin
            r_pos1   <= n_pos1;
            r_pos2   <= n_pos2;
            r_mag1   <= n_mag1;
            r_mag2   <= n_mag2;
            r_total  <= n_total;
            r_iter   <= n_iter;
            r_err1   <= n_err1;
            r_err2   <= n_err2;
            r_dir1   <= n_dir1;
            r_dir2   <= n_dir2;
            r_moving <= n_moving;
        end
    end

    // Result register: loaded on acceptance, cleared once downstream takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_beat <= n_out_beat;
        end
    end

    // A move in progress always has iterations left.
    a_iter_below_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_moving |-> (r_iter < r_total))
        else $error("iteration index reached the move length while still moving");

    // The error terms stay within (-n, 0] during a move.
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_moving |-> ((r_err1 <= $signed({ERR_BITS{1'b0}}))
                   && (r_err1 > -w_total_ext)
                   && (r_err2 <= $signed({ERR_BITS{1'b0}}))
                   && (r_err2 > -w_total_ext)))
        else $error("step error term left its range");

    // A step is only ever reported on a carried-out beat that was still busy before it.
    a_step_needs_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_step1 || w_step2)) |-> (r_moving && (r_total != '0)))
        else $error("step issued without a move in progress");

    // The first result after an accepted beat is valid on the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted request produced no result");

endmodule

`default_nettype wire

// ===== dv/tlsi_motion_check.sv =====
`timescale 1ns / 100ps
// Checker for the two-axis linear step interpolator: watches both channels, predicts
// every result beat from the accepted request beats and compares it field by field.
// Depends on tlsi_pkg.

module tlsi_motion_check
    import tlsi_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_stall,
    input  wire t_in_beat  i_in_beat,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_stall,
    input  wire t_out_beat i_out_beat,
    output int             o_fail_count,
    output int             o_pending
);

    localparam int PROD_BITS = 2 * POS_BITS;

    // Shadow of the move state, index 0 is motor 1 and index 1 is motor 2.
    logic [POS_BITS-1:0] axis_pos   [2];
    logic [POS_BITS-1:0] axis_mag   [2];
    logic [POS_BITS-1:0] axis_count [2];
    logic [1:0]          axis_fwd;
    logic [POS_BITS-1:0] move_len;
    logic [POS_BITS-1:0] move_iter;
    logic                in_motion;

    t_out_beat motion_results [$];
    t_out_beat fresh_result;
    int        mismatch_total = 0;
    int        pending_count  = 0;

    assign o_fail_count = mismatch_total;
    assign o_pending    = pending_count;

    task automatic report_mismatch(input string what);
        mismatch_total++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic clear_motion();
        for (int k = 0; k < 2; k++) begin
            axis_pos[k]   = '0;
            axis_mag[k]   = '0;
            axis_count[k] = '0;
        end
        axis_fwd  = 2'b11;
        move_len  = '0;
        move_iter = '0;
        in_motion = 1'b0;
    endtask

    // Carries one request beat through the shadow state and builds its result beat.
    task automatic advance_motion(input t_in_beat req, output t_out_beat res);
        logic signed [POS_BITS:0] delta;
        logic [POS_BITS-1:0]      target [2];
        logic [POS_BITS-1:0]      next_iter;
        logic [PROD_BITS-1:0]     done_part;
        logic [PROD_BITS-1:0]     due_part;
        logic [1:0]               stepped;
        logic                     carried;
        target[0] = req.axis1_value;
        target[1] = req.axis2_value;
        stepped   = 2'b00;
        carried   = 1'b0;
        case (req.action)
            ACT_MOVE: begin
                if (!in_motion) begin
                    for (int k = 0; k < 2; k++) begin
                        delta = $signed({target[k][POS_BITS-1], target[k]})
                              - $signed({axis_pos[k][POS_BITS-1], axis_pos[k]});
                        axis_fwd[k]   = ~delta[POS_BITS];
                        axis_mag[k]   = delta[POS_BITS] ? POS_BITS'(-delta)
                                                        : delta[POS_BITS-1:0];
                        axis_pos[k]   = target[k];
                        axis_count[k] = '0;
                    end
                    move_len  = (axis_mag[0] > axis_mag[1]) ? axis_mag[0] : axis_mag[1];
                    move_iter = '0;
                    in_motion = (move_len != '0);
                    carried   = 1'b1;
                end
            end
            ACT_TICK: begin
                carried = 1'b1;
                if (in_motion) begin
                    next_iter = move_iter + 1'b1;
                    for (int k = 0; k < 2; k++) begin
                        done_part = PROD_BITS'(axis_count[k]) * PROD_BITS'(move_len);
                        due_part  = PROD_BITS'(next_iter) * PROD_BITS'(axis_mag[k]);
                        if (done_part < due_part) begin
                            stepped[k]    = 1'b1;
                            axis_count[k] = axis_count[k] + 1'b1;
                        end
                    end
                    move_iter = next_iter;
                    if (next_iter >= move_len) begin
                        in_motion = 1'b0;
                    end
                end
            end
            ACT_SET: begin
                if (!in_motion) begin
                    axis_pos[0] = target[0];
                    axis_pos[1] = target[1];
                    carried     = 1'b1;
                end
            end
            default: begin
                // The spare action code leaves everything alone and is refused.
            end
        endcase
        res.step1     = stepped[0];
        res.step2     = stepped[1];
        res.dir1      = axis_fwd[0];
        res.dir2      = axis_fwd[1];
        res.position1 = axis_pos[0];
        res.position2 = axis_pos[1];
        res.busy_res  = in_motion;
        res.accepted  = carried;
    endtask

    task automatic compare_result(input t_out_beat got, input t_out_beat want);
        if (got.step1 !== want.step1)
            report_mismatch($sformatf("step1 %b, expected %b", got.step1, want.step1));
        if (got.step2 !== want.step2)
            report_mismatch($sformatf("step2 %b, expected %b", got.step2, want.step2));
        if (got.dir1 !== want.dir1)
            report_mismatch($sformatf("dir1 %b, expected %b", got.dir1, want.dir1));
        if (got.dir2 !== want.dir2)
            report_mismatch($sformatf("dir2 %b, expected %b", got.dir2, want.dir2));
        if (got.position1 !== want.position1)
            report_mismatch($sformatf("position1 %h, expected %h",
                                      got.position1, want.position1));
        if (got.position2 !== want.position2)
            report_mismatch($sformatf("position2 %h, expected %h",
                                      got.position2, want.position2));
        if (got.busy_res !== want.busy_res)
            report_mismatch($sformatf("busy_res %b, expected %b",
                                      got.busy_res, want.busy_res));
        if (got.accepted !== want.accepted)
            report_mismatch($sformatf("accepted %b, expected %b",
                                      got.accepted, want.accepted));
    endtask

    // The result side is handled before the request side, so a beat that turns up
    // with an empty store is flagged even when a request is taken on the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_motion();
            motion_results.delete();
            pending_count <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (motion_results.size() == 0) begin
                    report_mismatch($sformatf("result beat %h with nothing expected",
                                              i_out_beat));
                end else begin
                    compare_result(i_out_beat, motion_results.pop_front());
                end
            end
            if (i_in_valid && !i_in_stall) begin
                advance_motion(i_in_beat, fresh_result);
                motion_results.push_back(fresh_result);
            end
            pending_count <= motion_results.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the interpolator testbench: clock, reset, request stimulus, result-side
// stalls and the verdict. Depends on tlsi_pkg, the core and tlsi_motion_check.

module testbench;
    import tlsi_pkg::*;

    // The package names only three actions; the fourth code must still be sent.
    localparam t_action ACT_UNUSED   = t_action'(2'd3);
    localparam int      RANDOM_ITEMS = 600;
    localparam int      LONG_HOLD    = 400;
    // Ticks given to the full-range move at the end; it is left running.
    localparam int      BIG_MOVE_TICKS = 100;
    // The core answers in the cycle after a request, so a short settle is plenty.
    localparam int      SETTLE_CYCLES = 8;
    // The slowest correct run is about a thousand beats with their gaps and stalls,
    // plus the long hold; this limit is set well above that.
    localparam int      CYCLE_LIMIT   = 200_000;
    localparam int      POS_MAX       = 32767;
    localparam int      POS_MIN       = -32768;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_beat  in_beat;
    logic      out_valid;
    logic      out_stall;
    t_out_beat out_beat;
    int        fail_count;
    int        pending_count;

    // Stimulus-side bookkeeping. The sender tracks where the motors were told to go
    // and how many ticks the running move still needs, so that it can build moves
    // of a chosen length and know when presets and moves will be refused.
    int burst_left   = 0;
    int cur_pos1     = 0;
    int cur_pos2     = 0;
    int ticks_owed   = 0;
    int item_total   = 0;
    bit hold_request = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    two_axis_linear_step_interpolator_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat)
    );

    tlsi_motion_check motion_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_beat    (in_beat),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_beat   (out_beat),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // A position anywhere in range, with the two extremes picked more often.
    function automatic int rand_pos();
        case ($urandom_range(0, 7))
            0:       return POS_MIN;
            1:       return POS_MAX;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // Mostly short signed moves per axis, now and then none and now and then
    // 25 to 120 steps.
    function automatic int pick_delta();
        int roll;
        int span;
        roll = $urandom_range(0, 19);
        if (roll < 3) begin
            span = 0;
        end else if (roll == 19) begin
            span = $urandom_range(25, 120);
        end else begin
            span = $urandom_range(1, 24);
        end
        return $urandom_range(0, 1) ? span : -span;
    endfunction

    function automatic int distance(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Offers one request beat and returns at the edge that accepts it. Beats come in
    // bursts; a new burst may start right away or after a random gap with valid low.
    // Valid is left high on return, so the caller either offers the next beat at
    // once or lowers valid itself.
    task automatic offer_beat(input t_action act, input int value1, input int value2);
        int gap;
        int span1;
        int span2;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200)
                                                      : $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        in_beat  <= '{action: act,
                      axis1_value: POS_BITS'(value1),
                      axis2_value: POS_BITS'(value2)};
        do @(posedge clk); while (in_stall);
        burst_left--;
        item_total++;
        case (act)
            ACT_MOVE: begin
                if (ticks_owed == 0) begin
                    span1      = distance(value1, cur_pos1);
                    span2      = distance(value2, cur_pos2);
                    ticks_owed = (span1 > span2) ? span1 : span2;
                    cur_pos1   = value1;
                    cur_pos2   = value2;
                end
            end
            ACT_TICK: begin
                if (ticks_owed > 0) ticks_owed--;
            end
            ACT_SET: begin
                if (ticks_owed == 0) begin
                    cur_pos1 = value1;
                    cur_pos2 = value2;
                end
            end
            default: begin
            end
        endcase
    endtask

    // Stops offering, waits for every expected result beat and then for the settle time.
    // The first edge lets the checker's count catch up with the last beat.
    task automatic pause_for_results();
        in_valid  <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side: stretches of random length, each with its own stall rate, some
    // of them with no stalls at all. On request it holds off for a long stretch so
    // that the result register fills and the core stalls its request side.
    initial begin
        int span;
        int stall_pct;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end else begin
                span = $urandom_range(1, 50);
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 20;
                    3:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
                repeat (span) begin
                    out_stall <= ($urandom_range(0, 99) < stall_pct);
                    @(posedge clk);
                end
            end
        end
    end

    // Watchdog: a run that hangs ends here with the fail verdict.
    initial begin
        for (int n = 0; n < CYCLE_LIMIT; n++) @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int start_count;
        int roll;
        int delta1;
        int delta2;
        int target1;
        int target2;

        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_beat  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A tick straight out of reset does nothing but is taken,
        // and the spare action code is refused.
        offer_beat(ACT_TICK, 0, 0);
        offer_beat(ACT_UNUSED, POS_MIN, POS_MAX);
        // A move to where the motors already are stays idle, both forward.
        offer_beat(ACT_MOVE, 0, 0);
        // Preset to the extremes, then a short move backward on motor 1 and
        // forward on motor 2 with different lengths.
        offer_beat(ACT_SET, POS_MAX, POS_MIN);
        offer_beat(ACT_MOVE, POS_MAX - 7, POS_MIN + 8);
        offer_beat(ACT_TICK, 0, 0);
        // While the move runs, a move, a preset and the spare code are all refused.
        offer_beat(ACT_MOVE, 0, 0);
        offer_beat(ACT_SET, 1, 1);
        offer_beat(ACT_UNUSED, -1, -1);
        repeat (7) offer_beat(ACT_TICK, 0, 0);
        // Idle tick after the move has finished.
        offer_beat(ACT_TICK, 0, 0);
        // A preset keeps the directions of the last move.
        offer_beat(ACT_SET, POS_MIN, POS_MAX);
        offer_beat(ACT_MOVE, POS_MIN, POS_MAX);
        // Only motor 1 moves; motor 2 must never step.
        offer_beat(ACT_MOVE, POS_MIN + 3, POS_MAX);
        repeat (3) offer_beat(ACT_TICK, 0, 0);
        offer_beat(ACT_SET, -1, 0);
        pause_for_results();

        // Random part. The long result-side hold starts once the current stall stretch
        // ends, while beats keep coming. Most of the traffic is well-formed moves ticked out to the end,
        // with refused requests and spare codes mixed into running moves.
        hold_request = 1'b1;
        start_count  = item_total;
        while (item_total - start_count < RANDOM_ITEMS || ticks_owed != 0) begin
            roll = $urandom_range(0, 99);
            if (ticks_owed != 0) begin
                if (roll < 80) begin
                    offer_beat(ACT_TICK, rand_pos(), rand_pos());
                end else if (roll < 88) begin
                    offer_beat(ACT_MOVE, rand_pos(), rand_pos());
                end else if (roll < 94) begin
                    offer_beat(ACT_SET, rand_pos(), rand_pos());
                end else begin
                    offer_beat(ACT_UNUSED, rand_pos(), rand_pos());
                end
            end else if (roll < 3) begin
                pause_for_results();
            end else if (roll < 15) begin
                offer_beat(ACT_SET, rand_pos(), rand_pos());
            end else if (roll < 70) begin
                delta1  = pick_delta();
                delta2  = pick_delta();
                target1 = cur_pos1 + delta1;
                target2 = cur_pos2 + delta2;
                if (target1 > POS_MAX || target1 < POS_MIN) target1 = cur_pos1 - delta1;
                if (target2 > POS_MAX || target2 < POS_MIN) target2 = cur_pos2 - delta2;
                offer_beat(ACT_MOVE, target1, target2);
            end else if (roll < 80) begin
                offer_beat(ACT_TICK, rand_pos(), rand_pos());
            end else if (roll < 88) begin
                offer_beat(ACT_UNUSED, rand_pos(), rand_pos());
            end else begin
                offer_beat(ACT_MOVE, cur_pos1, cur_pos2);
            end
        end

        // One move across the whole range on motor 1 gives the largest delta and
        // move length; motor 2 covers a random share of it. Only its first
        // iterations are ticked, and the move is left running at the end.
        offer_beat(ACT_SET, POS_MAX, rand_pos());
        offer_beat(ACT_MOVE, POS_MIN, rand_pos());
        repeat (BIG_MOVE_TICKS) offer_beat(ACT_TICK, 0, 0);
        pause_for_results();

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/tlsi_pkg.sv
hw/rtl/two_axis_linear_step_interpolator_core.sv
dv/tlsi_motion_check.sv
dv/testbench.sv
